[rtl/wlc_pkg.sv]
// Package for the windowed LFM chirp generator.
// Holds the configuration register map, the configuration struct and the cosine table builder.
// Depends on nothing; every module of the block imports it.
package wlc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PULSE_LEN_W = 21;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int HAM_A = 17695;
    localparam int HAM_B = 15073;

    // Series divisors are applied as rounded-up reciprocals scaled by 2^48, which gives
    // an exact floor quotient for every dividend below 2^40.
    localparam int          TAYLOR_SHIFT = 48;
    localparam logic [63:0] TAYLOR_ONE   = 64'd1 << TAYLOR_SHIFT;
    localparam logic [63:0] RECIP_2      = (TAYLOR_ONE + 64'd1) / 64'd2;
    localparam logic [63:0] RECIP_12     = (TAYLOR_ONE + 64'd11) / 64'd12;
    localparam logic [63:0] RECIP_30     = (TAYLOR_ONE + 64'd29) / 64'd30;
    localparam logic [63:0] RECIP_56     = (TAYLOR_ONE + 64'd55) / 64'd56;
    localparam logic [63:0] RECIP_90     = (TAYLOR_ONE + 64'd89) / 64'd90;
    localparam logic [63:0] RECIP_132    = (TAYLOR_ONE + 64'd131) / 64'd132;
    localparam logic [63:0] RECIP_182    = (TAYLOR_ONE + 64'd181) / 64'd182;
    localparam logic [63:0] RECIP_240    = (TAYLOR_ONE + 64'd239) / 64'd240;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_PHASE_STEP = 3'd0,
        CFG_SWEEP_STEP       = 3'd1,
        CFG_PULSE_LENGTH     = 3'd2,
        CFG_WINDOW_STEP      = 3'd3,
        CFG_WINDOW_ENABLE    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [31:0]            start_phase_step;
        logic signed [31:0]     sweep_step;
        logic [PULSE_LEN_W-1:0] pulse_length;
        logic [31:0]            window_step;
        logic                   window_enable;
    } cfg_t;

    function automatic logic [63:0] taylor_recip(input int i);
        logic [63:0] m;
        case (i)
            1:       m = RECIP_2;
            2:       m = RECIP_12;
            3:       m = RECIP_30;
            4:       m = RECIP_56;
            5:       m = RECIP_90;
            6:       m = RECIP_132;
            7:       m = RECIP_182;
            8:       m = RECIP_240;
            default: m = TAYLOR_ONE;
        endcase
        return m;
    endfunction

    // One quarter-wave cosine entry, evaluated at elaboration only.
    function automatic logic [63:0] cos_entry(
        input logic [63:0] k,
        input int          addr_bits,
        input int          frac_bits
    );
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic [63:0]        maxv;
        logic [127:0]       scaled;
        logic signed [63:0] sum;
        int                 i;
        x    = (k * HALF_PI_Q30) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = $signed(term);
        for (i = 1; i <= 8; i++)
        begin
            scaled = 128'((term * x2) >> 30) * 128'(taylor_recip(i));
            term   = 64'(scaled >> TAYLOR_SHIFT);
            if (i[0])
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v    = ($unsigned(sum) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
        maxv = (64'd1 << frac_bits) - 64'd1;
        if (v > maxv)
        begin
            v = maxv;
        end
        return v;
    endfunction

endpackage

[rtl/wlc_cos_rom.sv]
// Quarter-wave cosine lookup: magnitude and sign of cos() for the top bits of a phase.
// Depends on wlc_pkg for the table builder.
module wlc_cos_rom #(
    parameter int PHASE_BITS          = 32,
    parameter int SAMPLE_BITS         = 16,
    parameter int COS_TABLE_ADDR_BITS = 10
) (
    input  logic [PHASE_BITS-1:0]  phase,
    output logic [SAMPLE_BITS-2:0] mag,
    output logic                   neg
);
    import wlc_pkg::*;

    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int A         = COS_TABLE_ADDR_BITS;
    localparam int QTR       = 1 << (A - 2);

    logic [FRAC_BITS-1:0] rom [QTR+1];
    logic [A-1:0]         idx;
    logic [1:0]           quad;
    logic [A-3:0]         r;
    logic [A-2:0]         k;

    for (genvar g = 0; g <= QTR; g++)
    begin : g_rom
        localparam logic [63:0] ENTRY = cos_entry(64'(g), A, FRAC_BITS);
        assign rom[g] = ENTRY[FRAC_BITS-1:0];
    end

    always_comb
    begin
        idx  = phase[PHASE_BITS-1 -: A];
        quad = idx[A-1 -: 2];
        r    = idx[A-3:0];
        if (quad[0])
        begin
            k = (A-1)'(QTR) - (A-1)'(r);
        end
        else
        begin
            k = (A-1)'(r);
        end
        mag = rom[k];
        neg = quad[1] ^ quad[0];
    end

endmodule

[rtl/wlc_cfg_regs.sv]
// Configuration register file of the chirp generator, written through its own transfer channel.
// Depends on wlc_pkg for the register map and the configuration struct.
module wlc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wlc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wlc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wlc_pkg::cfg_t                   cfg
);
    import wlc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_PHASE_STEP: cfg_next.start_phase_step = cfg_data;
                CFG_SWEEP_STEP:       cfg_next.sweep_step       = $signed(cfg_data);
                CFG_PULSE_LENGTH:     cfg_next.pulse_length     = cfg_data[PULSE_LEN_W-1:0];
                CFG_WINDOW_STEP:      cfg_next.window_step      = cfg_data;
                CFG_WINDOW_ENABLE:    cfg_next.window_enable    = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_phase_step <= '0;
            cfg_reg.sweep_step       <= '0;
            cfg_reg.pulse_length     <= PULSE_LEN_W'(1);
            cfg_reg.window_step      <= '0;
            cfg_reg.window_enable    <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/wlc_phase_gen.sv]
// Pulse sequencer: carrier phase, frequency word, window phase and sample position.
// Registers the phases of each sample for the shaping pipeline. Depends on wlc_pkg.
module wlc_phase_gen #(
    parameter int PHASE_BITS  = 32,
    parameter int LENGTH_BITS = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wlc_pkg::cfg_t          cfg,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   restart,
    input  logic                   s1_ready,
    output logic                   s1_valid,
    output logic [PHASE_BITS-1:0]  s1_phase,
    output logic [PHASE_BITS-1:0]  s1_wphase,
    output logic [LENGTH_BITS-1:0] s1_index,
    output logic                   s1_last,
    output logic                   s1_win_en
);
    import wlc_pkg::*;

    localparam int CMP_W = (LENGTH_BITS + 1 > PULSE_LEN_W) ? LENGTH_BITS + 1 : PULSE_LEN_W;

    logic [PHASE_BITS-1:0]  phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS-1:0]  freq_acc_reg, freq_acc_next;
    logic [PHASE_BITS-1:0]  window_phase_reg, window_phase_next;
    logic [LENGTH_BITS-1:0] position_reg, position_next;
    logic                   active_reg, active_next;

    logic                   s1_valid_reg, s1_valid_next;
    logic [PHASE_BITS-1:0]  s1_phase_reg, s1_phase_next;
    logic [PHASE_BITS-1:0]  s1_wphase_reg, s1_wphase_next;
    logic [LENGTH_BITS-1:0] s1_index_reg, s1_index_next;
    logic                   s1_last_reg, s1_last_next;
    logic                   s1_win_en_reg, s1_win_en_next;

    logic                   slot_open;
    logic                   accept;
    logic [PHASE_BITS-1:0]  eff_phase;
    logic [PHASE_BITS-1:0]  eff_freq;
    logic [PHASE_BITS-1:0]  eff_wphase;
    logic [LENGTH_BITS-1:0] eff_pos;
    logic                   eff_active;
    logic [PHASE_BITS-1:0]  sweep_ext;
    logic [CMP_W-1:0]       len_limit;
    logic [CMP_W-1:0]       len_word;
    logic [CMP_W-1:0]       len_m1;
    logic                   is_last;

    assign slot_open = !s1_valid_reg || s1_ready;
    assign in_stall  = !slot_open;
    assign accept    = in_valid && slot_open;

    assign s1_valid  = s1_valid_reg;
    assign s1_phase  = s1_phase_reg;
    assign s1_wphase = s1_wphase_reg;
    assign s1_index  = s1_index_reg;
    assign s1_last   = s1_last_reg;
    assign s1_win_en = s1_win_en_reg;

    always_comb
    begin
        if (restart)
        begin
            eff_phase  = '0;
            eff_freq   = PHASE_BITS'(cfg.start_phase_step);
            eff_wphase = '0;
            eff_pos    = '0;
            eff_active = 1'b1;
        end
        else
        begin
            eff_phase  = phase_acc_reg;
            eff_freq   = freq_acc_reg;
            eff_wphase = window_phase_reg;
            eff_pos    = position_reg;
            eff_active = active_reg;
        end

        sweep_ext = PHASE_BITS'(cfg.sweep_step);
        len_limit = CMP_W'(1) << LENGTH_BITS;
        len_word  = CMP_W'(cfg.pulse_length);
        if (len_word == '0)
        begin
            len_m1 = '0;
        end
        else if (len_word > len_limit)
        begin
            len_m1 = len_limit - CMP_W'(1);
        end
        else
        begin
            len_m1 = len_word - CMP_W'(1);
        end
        is_last = (CMP_W'(eff_pos) == len_m1);

        phase_acc_next    = phase_acc_reg;
        freq_acc_next     = freq_acc_reg;
        window_phase_next = window_phase_reg;
        position_next     = position_reg;
        active_next       = active_reg;
        if (accept && eff_active)
        begin
            phase_acc_next    = eff_phase + eff_freq;
            freq_acc_next     = eff_freq + sweep_ext;
            window_phase_next = eff_wphase + PHASE_BITS'(cfg.window_step);
            position_next     = eff_pos + LENGTH_BITS'(1);
            active_next       = !is_last;
        end

        s1_valid_next  = s1_valid_reg;
        s1_phase_next  = s1_phase_reg;
        s1_wphase_next = s1_wphase_reg;
        s1_index_next  = s1_index_reg;
        s1_last_next   = s1_last_reg;
        s1_win_en_next = s1_win_en_reg;
        if (slot_open)
        begin
            s1_valid_next  = accept && eff_active;
            s1_phase_next  = eff_phase;
            s1_wphase_next = eff_wphase;
            s1_index_next  = eff_pos;
            s1_last_next   = is_last;
            s1_win_en_next = cfg.window_enable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            freq_acc_reg     <= '0;
            window_phase_reg <= '0;
            position_reg     <= '0;
            active_reg       <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_acc_reg    <= phase_acc_next;
            freq_acc_reg     <= freq_acc_next;
            window_phase_reg <= window_phase_next;
            position_reg     <= position_next;
            active_reg       <= active_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_phase_reg  <= s1_phase_next;
        s1_wphase_reg <= s1_wphase_next;
        s1_index_reg  <= s1_index_next;
        s1_last_reg   <= s1_last_next;
        s1_win_en_reg <= s1_win_en_next;
    end

endmodule

[rtl/wlc_shaper.sv]
// Sample shaping pipeline: cosine lookups, Hamming weight, windowed product and output register.
// Three registered stages with per-stage flow control. Depends on wlc_pkg and wlc_cos_rom.
module wlc_shaper #(
    parameter int PHASE_BITS          = 32,
    parameter int SAMPLE_BITS         = 16,
    parameter int LENGTH_BITS         = 20,
    parameter int COS_TABLE_ADDR_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s1_valid,
    output logic                          s1_ready,
    input  logic [PHASE_BITS-1:0]         s1_phase,
    input  logic [PHASE_BITS-1:0]         s1_wphase,
    input  logic [LENGTH_BITS-1:0]        s1_index,
    input  logic                          s1_last,
    input  logic                          s1_win_en,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic [LENGTH_BITS-1:0]        sample_index,
    output logic                          last
);
    import wlc_pkg::*;

    localparam int F   = SAMPLE_BITS - 1;
    localparam int W_W = 15 + F;
    localparam int WF_W = W_W + 2;
    localparam int P_W = W_W + F + 1;

    logic [F-1:0] c_mag;
    logic         c_neg;
    logic [F-1:0] wc_mag;
    logic         wc_neg;

    logic                          en2, en3, en4;

    logic                          s2_valid_reg, s2_valid_next;
    logic [F-1:0]                  s2_cmag_reg, s2_cmag_next;
    logic                          s2_cneg_reg, s2_cneg_next;
    logic signed [SAMPLE_BITS-1:0] s2_wc_reg, s2_wc_next;
    logic                          s2_win_en_reg, s2_win_en_next;
    logic [LENGTH_BITS-1:0]        s2_index_reg, s2_index_next;
    logic                          s2_last_reg, s2_last_next;

    logic                          s3_valid_reg, s3_valid_next;
    logic [F-1:0]                  s3_cmag_reg, s3_cmag_next;
    logic                          s3_cneg_reg, s3_cneg_next;
    logic [W_W-1:0]                s3_w_reg, s3_w_next;
    logic                          s3_win_en_reg, s3_win_en_next;
    logic [LENGTH_BITS-1:0]        s3_index_reg, s3_index_next;
    logic                          s3_last_reg, s3_last_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [LENGTH_BITS-1:0]        index_reg, index_next;
    logic                          last_reg, last_next;

    logic signed [WF_W-1:0]        w_full;
    logic [P_W-1:0]                prod;
    logic [F-1:0]                  out_mag;

    wlc_cos_rom #(
        .PHASE_BITS          (PHASE_BITS),
        .SAMPLE_BITS         (SAMPLE_BITS),
        .COS_TABLE_ADDR_BITS (COS_TABLE_ADDR_BITS)
    ) u_chirp_rom (
        .phase (s1_phase),
        .mag   (c_mag),
        .neg   (c_neg)
    );

    wlc_cos_rom #(
        .PHASE_BITS          (PHASE_BITS),
        .SAMPLE_BITS         (SAMPLE_BITS),
        .COS_TABLE_ADDR_BITS (COS_TABLE_ADDR_BITS)
    ) u_window_rom (
        .phase (s1_wphase),
        .mag   (wc_mag),
        .neg   (wc_neg)
    );

    assign en4      = !out_valid_reg || !out_stall;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign s1_ready = en2;

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign sample_index = index_reg;
    assign last         = last_reg;

    always_comb
    begin
        s2_valid_next  = s2_valid_reg;
        s2_cmag_next   = s2_cmag_reg;
        s2_cneg_next   = s2_cneg_reg;
        s2_wc_next     = s2_wc_reg;
        s2_win_en_next = s2_win_en_reg;
        s2_index_next  = s2_index_reg;
        s2_last_next   = s2_last_reg;
        if (en2)
        begin
            s2_valid_next  = s1_valid;
            s2_cmag_next   = c_mag;
            s2_cneg_next   = c_neg;
            s2_wc_next     = wc_neg ? -$signed(SAMPLE_BITS'(wc_mag))
                                    : $signed(SAMPLE_BITS'(wc_mag));
            s2_win_en_next = s1_win_en;
            s2_index_next  = s1_index;
            s2_last_next   = s1_last;
        end

        // Hamming weight 0.54 - 0.46 * cos, scaled by 2^15 * 2^F; always positive.
        w_full = ($signed(WF_W'(HAM_A)) <<< F)
                 - $signed(WF_W'(HAM_B)) * WF_W'(s2_wc_reg);

        s3_valid_next  = s3_valid_reg;
        s3_cmag_next   = s3_cmag_reg;
        s3_cneg_next   = s3_cneg_reg;
        s3_w_next      = s3_w_reg;
        s3_win_en_next = s3_win_en_reg;
        s3_index_next  = s3_index_reg;
        s3_last_next   = s3_last_reg;
        if (en3)
        begin
            s3_valid_next  = s2_valid_reg;
            s3_cmag_next   = s2_cmag_reg;
            s3_cneg_next   = s2_cneg_reg;
            s3_w_next      = w_full[W_W-1:0];
            s3_win_en_next = s2_win_en_reg;
            s3_index_next  = s2_index_reg;
            s3_last_next   = s2_last_reg;
        end

        prod = P_W'(s3_cmag_reg) * P_W'(s3_w_reg) + (P_W'(1) << (14 + F));
        if (s3_win_en_reg)
        begin
            out_mag = prod[15 + F +: F];
        end
        else
        begin
            out_mag = s3_cmag_reg;
        end

        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        if (en4)
        begin
            out_valid_next = s3_valid_reg;
            sample_next    = s3_cneg_reg ? -$signed(SAMPLE_BITS'(out_mag))
                                         : $signed(SAMPLE_BITS'(out_mag));
            index_next     = s3_index_reg;
            last_next      = s3_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cmag_reg   <= s2_cmag_next;
        s2_cneg_reg   <= s2_cneg_next;
        s2_wc_reg     <= s2_wc_next;
        s2_win_en_reg <= s2_win_en_next;
        s2_index_reg  <= s2_index_next;
        s2_last_reg   <= s2_last_next;
        s3_cmag_reg   <= s3_cmag_next;
        s3_cneg_reg   <= s3_cneg_next;
        s3_w_reg      <= s3_w_next;
        s3_win_en_reg <= s3_win_en_next;
        s3_index_reg  <= s3_index_next;
        s3_last_reg   <= s3_last_next;
        sample_reg    <= sample_next;
        index_reg     <= index_next;
        last_reg      <= last_next;
    end

endmodule

[rtl/windowed_lfm_chirp_generator.sv]
// Windowed linear FM chirp generator, top level.
// A sample passes the phase register, the lookup register, the weight register and the output register.
// Throughput: one tick per cycle; the pipeline advances whenever the output is not stalled.
// The depth is set by the phase register, the cosine lookup stage and the two multiplications.
// Reset clears the accumulators, puts the block in idle and loads the register defaults.
// Depends on wlc_pkg, wlc_cfg_regs, wlc_phase_gen, wlc_shaper and wlc_cos_rom.
module windowed_lfm_chirp_generator #(
    parameter int PHASE_BITS          = 32,
    parameter int SAMPLE_BITS         = 16,
    parameter int LENGTH_BITS         = 20,
    parameter int COS_TABLE_ADDR_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wlc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wlc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [SAMPLE_BITS-1:0]   sample,
    output logic [LENGTH_BITS-1:0]          sample_index,
    output logic                            last
);
    import wlc_pkg::*;

    cfg_t                   cfg;
    logic                   s1_valid;
    logic                   s1_ready;
    logic [PHASE_BITS-1:0]  s1_phase;
    logic [PHASE_BITS-1:0]  s1_wphase;
    logic [LENGTH_BITS-1:0] s1_index;
    logic                   s1_last;
    logic                   s1_win_en;

    wlc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wlc_phase_gen #(
        .PHASE_BITS  (PHASE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_phase_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .s1_ready  (s1_ready),
        .s1_valid  (s1_valid),
        .s1_phase  (s1_phase),
        .s1_wphase (s1_wphase),
        .s1_index  (s1_index),
        .s1_last   (s1_last),
        .s1_win_en (s1_win_en)
    );

    wlc_shaper #(
        .PHASE_BITS          (PHASE_BITS),
        .SAMPLE_BITS         (SAMPLE_BITS),
        .LENGTH_BITS         (LENGTH_BITS),
        .COS_TABLE_ADDR_BITS (COS_TABLE_ADDR_BITS)
    ) u_shaper (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1_phase     (s1_phase),
        .s1_wphase    (s1_wphase),
        .s1_index     (s1_index),
        .s1_last      (s1_last),
        .s1_win_en    (s1_win_en),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample),
        .sample_index (sample_index),
        .last         (last)
    );

endmodule
